>>> rtl/core/gqg_pkg.sv
// Shared types, constants and helper functions for the glyph quad generator.
package gqg_pkg;

  // Default table depth, one entry per character code
  localparam int DEF_GLYPH_COUNT = 256;

  // Atlas edge in pixels; power of two, so the texture scale is a pair of shifts
  localparam int ATLAS_SIZE = 256;
  localparam int ATLAS_LOG2 = $clog2(ATLAS_SIZE);
  localparam int TEX_FRAC   = 8;
  localparam int TEX_W      = 9;
  localparam int TEX_T_W    = TEX_W + TEX_FRAC + 4;
  localparam logic [TEX_W-1:0] TEX_MAX = '1;

  // Width of the exact position sums before saturation
  localparam int SUM_W = 20;

  localparam logic [7:0]  LINE_HEIGHT_RST = 8'd32;
  localparam logic [31:0] TEXT_COLOR_RST  = 32'hFFFF_FFFF;

  // Corner order of the two triangles: bit k marks use of the max edge
  localparam logic [5:0] CORNER_HI_X = 6'b001110;
  localparam logic [5:0] CORNER_HI_Y = 6'b011100;
  localparam logic [2:0] CORNER_FIRST = 3'd0;
  localparam logic [2:0] CORNER_LAST  = 3'd5;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_RENDER = 2'd2
  } gqg_func_t;

  typedef enum logic [1:0] {
    CFG_RISE_Y      = 2'd0,
    CFG_LINE_HEIGHT = 2'd1,
    CFG_TEXT_COLOR  = 2'd2
  } gqg_cfg_idx_t;

  typedef struct packed {
    gqg_func_t          func;
    logic [7:0]         char_code;
    logic [7:0]         atlas_x;
    logic [7:0]         atlas_y;
    logic [7:0]         glyph_w;
    logic [7:0]         glyph_h;
    logic signed [7:0]  off_x;
    logic signed [7:0]  off_y;
    logic [7:0]         advance;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } gqg_in_t;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [31:0]        color;
    logic [2:0]         corner;
    logic               last_of_glyph;
  } gqg_out_t;

  typedef struct packed {
    logic [7:0]        atlas_x;
    logic [7:0]        atlas_y;
    logic [7:0]        glyph_w;
    logic [7:0]        glyph_h;
    logic signed [7:0] off_x;
    logic signed [7:0] off_y;
    logic [7:0]        advance;
  } gqg_entry_t;

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -SUM_W'(32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Atlas pixel to texture units of 1/256, clamped at the top code
  function automatic logic [TEX_W-1:0] tex_coord(input logic [TEX_W-1:0] pix);
    logic [TEX_T_W-1:0] t;
    t = (TEX_T_W'(pix) << TEX_FRAC) >> ATLAS_LOG2;
    if (t > TEX_T_W'(TEX_MAX)) begin
      return TEX_MAX;
    end
    return t[TEX_W-1:0];
  endfunction

endpackage

>>> rtl/core/glyph_quad_generator.sv
// Glyph quad generator: glyph table, pen state and six-vertex quad emitter.
//
// Input channel (in_valid / in_stall / in_word) takes one command word per
// cycle while in_stall is low: load a glyph entry, set the pen start, or
// render a character. Output channel (out_valid / out_stall / out_word)
// gives one vertex word per cycle while out_stall is low; a rendered
// character yields six vertices, corners 0..5, last_of_glyph on corner 5.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; write it only while the block is idle.
// A render word is registered in the lookup stage, then loads the quad
// register, which sends its six vertices through the single vertex output
// port while the next word is looked up. Unknown glyphs, loads and pen
// starts retire from the lookup stage and yield no vertices.
// Reset clears all glyph valid marks (table data stays undefined), zeroes
// the pen and restores the config defaults.
// A stalled receiver freezes the current vertex; the lookup stage then holds
// a pending render and raises in_stall until the quad register frees up.
module glyph_quad_generator
  import gqg_pkg::*;
#(
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  gqg_in_t     in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output gqg_out_t    out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // Config registers
  logic signed [15:0] rise_y;
  logic [7:0]         line_height;
  logic [31:0]        text_color;

  // Glyph table: data in a memory, valid marks in flops
  gqg_entry_t             glyph_mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] glyph_vld;

  // Lookup stage
  logic               s1_valid;
  gqg_func_t          s1_func;
  logic               s1_hit;
  logic signed [15:0] s1_start_x;
  logic signed [15:0] s1_start_y;
  gqg_entry_t         rd_entry;

  // Pen
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;

  // Quad register, emitted one corner a cycle while out_stall is low
  logic               q_valid;
  logic [2:0]         corner;
  logic signed [15:0] q_x0, q_x1, q_y0, q_y1;
  logic [TEX_W-1:0]   q_u0, q_u1, q_v0, q_v1;
  logic [31:0]        q_color;

  logic             in_accept;
  logic [IDX_W-1:0] idx;
  logic             code_in_range;
  gqg_entry_t       entry_in;
  logic             s1_emit;
  logic             s1_retire;
  logic             q_done;
  logic             q_free;

  logic signed [SUM_W-1:0] x0, x1, ybase, y0, pen_adv;
  logic signed [15:0]      sx0, sx1, sy0, sy1, pen_x_next;
  logic [TEX_W-1:0]        u0, u1, v0, v1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_y      <= '0;
      line_height <= LINE_HEIGHT_RST;
      text_color  <= TEXT_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RISE_Y:      rise_y      <= cfg_data[15:0];
        CFG_LINE_HEIGHT: line_height <= cfg_data[7:0];
        CFG_TEXT_COLOR:  text_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx           = in_word.char_code[IDX_W-1:0];
  assign code_in_range = ({1'b0, in_word.char_code} < 9'(GLYPH_COUNT));

  assign entry_in = '{
    atlas_x: in_word.atlas_x, atlas_y: in_word.atlas_y,
    glyph_w: in_word.glyph_w, glyph_h: in_word.glyph_h,
    off_x:   in_word.off_x,   off_y:   in_word.off_y,
    advance: in_word.advance
  };

  // Handshake: the lookup stage retires when it needs no quad slot or one frees
  assign s1_emit   = (s1_func == FUNC_RENDER) && s1_hit;
  assign q_done    = q_valid && !out_stall && (corner == CORNER_LAST);
  assign q_free    = !q_valid || q_done;
  assign s1_retire = s1_valid && (!s1_emit || q_free);
  assign in_stall  = s1_valid && !s1_retire;
  assign in_accept = in_valid && !in_stall;

  // Table write on load, registered read on every accepted word
  always_ff @(posedge clk) begin
    if (in_accept && (in_word.func == FUNC_LOAD) && code_in_range) begin
      glyph_mem[idx] <= entry_in;
    end
    if (in_accept) begin
      rd_entry <= glyph_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_vld <= '0;
    end else if (in_accept && (in_word.func == FUNC_LOAD) && code_in_range) begin
      glyph_vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  // Valid mark is sampled with the data so a later load cannot slip in between
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func    <= in_word.func;
      s1_hit     <= code_in_range && glyph_vld[idx];
      s1_start_x <= in_word.start_x;
      s1_start_y <= in_word.start_y;
    end
  end

  // Quad geometry from pen, entry and config
  always_comb begin
    x0      = SUM_W'(pen_x) + SUM_W'(rd_entry.off_x);
    x1      = x0 + SUM_W'({1'b0, rd_entry.glyph_w});
    ybase   = SUM_W'(pen_y) + SUM_W'({1'b0, line_height}) - SUM_W'(rd_entry.off_y)
              + SUM_W'(rise_y);
    y0      = ybase - SUM_W'({1'b0, rd_entry.glyph_h});
    pen_adv = SUM_W'(pen_x) + SUM_W'({1'b0, rd_entry.advance});
    sx0        = sat16(x0);
    sx1        = sat16(x1);
    sy0        = sat16(y0);
    sy1        = sat16(ybase);
    pen_x_next = sat16(pen_adv);
    u0 = tex_coord({1'b0, rd_entry.atlas_x});
    u1 = tex_coord(TEX_W'(rd_entry.atlas_x) + TEX_W'(rd_entry.glyph_w));
    v0 = tex_coord({1'b0, rd_entry.atlas_y});
    v1 = tex_coord(TEX_W'(rd_entry.atlas_y) + TEX_W'(rd_entry.glyph_h));
  end

  // Pen updates in retire order
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (s1_retire) begin
      if (s1_func == FUNC_START) begin
        pen_x <= s1_start_x;
        pen_y <= s1_start_y;
      end else if (s1_emit) begin
        pen_x <= pen_x_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      corner  <= CORNER_FIRST;
    end else if (s1_retire && s1_emit) begin
      q_valid <= 1'b1;
      corner  <= CORNER_FIRST;
    end else if (q_done) begin
      q_valid <= 1'b0;
    end else if (q_valid && !out_stall) begin
      corner <= corner + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && s1_emit) begin
      q_x0    <= sx0;
      q_x1    <= sx1;
      q_y0    <= sy0;
      q_y1    <= sy1;
      q_u0    <= u0;
      q_u1    <= u1;
      q_v0    <= v0;
      q_v1    <= v1;
      q_color <= text_color;
    end
  end

  // Pick the corner's edges
  assign out_valid              = q_valid;
  assign out_word.vert_x        = CORNER_HI_X[corner] ? q_x1 : q_x0;
  assign out_word.vert_y        = CORNER_HI_Y[corner] ? q_y1 : q_y0;
  assign out_word.tex_u         = CORNER_HI_X[corner] ? q_u1 : q_u0;
  assign out_word.tex_v         = CORNER_HI_Y[corner] ? q_v0 : q_v1;
  assign out_word.color         = q_color;
  assign out_word.corner        = corner;
  assign out_word.last_of_glyph = (corner == CORNER_LAST);

endmodule

>>> sim/glyph_quad_generator_test.sv
// Self-checking testbench for the glyph quad generator: command stream in, vertex stream checked.
module glyph_quad_generator_test;
  import gqg_pkg::*;

  // The command encoding leaves one func value unused; the block must drop it
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Cycles with no transfer on any channel before the run is declared hung.
  // The worst legal gap is a receiver stall burst, a sender idle gap or the
  // settle pause between phases, so this is many times over.
  localparam int STUCK_LIMIT   = 2000;
  // A render passes the lookup stage and the quad register before its first
  // vertex shows; loads and pen starts retire from the lookup stage.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS   = 92;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gqg_in_t     in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gqg_out_t    out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  glyph_quad_generator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block: glyph table, pen and register file
  logic               glyph_known [DEF_GLYPH_COUNT];
  gqg_entry_t         glyph_rec [DEF_GLYPH_COUNT];
  logic signed [15:0] pen_x_now;
  logic signed [15:0] pen_y_now;
  logic signed [15:0] rise_now;
  logic [7:0]         line_h_now;
  logic [31:0]        color_now;

  // Vertices predicted but not yet seen, oldest first
  gqg_out_t expected_verts [$];
  gqg_out_t want_vert;

  // Command words waiting for the driver
  gqg_in_t cmd_q [$];

  // Stimulus-side record of which codes have a glyph loaded
  bit stim_loaded [256];
  int loaded_codes [$];

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int stuck_cycles = 0;

  int words_taken = 0;
  int chars_drawn = 0;
  int chars_dropped = 0;
  int verts_checked = 0;
  int errors = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Atlas pixel to 1/256 texture units, pinned at the top of the 9-bit range
  function automatic logic [8:0] atlas_units(input int pix);
    int t;
    t = pix * 256 / ATLAS_SIZE;
    if (t > 511) begin
      return 9'd511;
    end
    return t[8:0];
  endfunction

  // Apply one accepted command to the shadow state and queue the vertices it yields
  task automatic apply_command(input gqg_in_t w);
    gqg_entry_t g;
    gqg_out_t   v;
    int         x0, y0, x1, y1;
    logic [8:0] tu0, tu1, tv0, tv1;
    bit         hi_x, hi_y;
    case (w.func)
      FUNC_LOAD: begin
        glyph_known[w.char_code] = 1'b1;
        glyph_rec[w.char_code] = '{atlas_x: w.atlas_x, atlas_y: w.atlas_y,
                                   glyph_w: w.glyph_w, glyph_h: w.glyph_h,
                                   off_x: w.off_x, off_y: w.off_y,
                                   advance: w.advance};
      end
      FUNC_START: begin
        pen_x_now = w.start_x;
        pen_y_now = w.start_y;
      end
      FUNC_RENDER: begin
        if (!glyph_known[w.char_code]) begin
          // unknown glyph: nothing comes out and the pen stays put
          chars_dropped++;
        end else begin
          g = glyph_rec[w.char_code];
          // keep sums exact in 32 bits, clamp only per vertex
          x0 = int'(pen_x_now) + int'(g.off_x);
          y0 = int'(pen_y_now) + int'(line_h_now) - int'(g.off_y) - int'(g.glyph_h);
          x1 = x0 + int'(g.glyph_w);
          y1 = y0 + int'(g.glyph_h);
          tu0 = atlas_units(int'(g.atlas_x));
          tu1 = atlas_units(int'(g.atlas_x) + int'(g.glyph_w));
          tv0 = atlas_units(int'(g.atlas_y));
          tv1 = atlas_units(int'(g.atlas_y) + int'(g.glyph_h));
          // corners 1..3 sit on the right edge, 2..4 on the bottom edge
          for (int k = 0; k < 6; k++) begin
            hi_x = (k >= 1 && k <= 3);
            hi_y = (k >= 2 && k <= 4);
            v.vert_x = clamp16(hi_x ? x1 : x0);
            v.vert_y = clamp16((hi_y ? y1 : y0) + int'(rise_now));
            v.tex_u = hi_x ? tu1 : tu0;
            v.tex_v = hi_y ? tv0 : tv1;
            v.color = color_now;
            v.corner = 3'(k);
            v.last_of_glyph = (k == 5);
            expected_verts.push_back(v);
          end
          pen_x_now = clamp16(int'(pen_x_now) + int'(g.advance));
          chars_drawn++;
        end
      end
      default: begin
        // unused func: no state change, no output
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag(input string msg);
    $error("%s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      flag($sformatf("%s: expected %0d, got %0d", name, expv, actv));
    end
  endtask

  // Monitor: compare each accepted vertex word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_verts.size() == 0) begin
        flag($sformatf("vertex word with nothing predicted: x=%0d y=%0d corner=%0d",
                       out_word.vert_x, out_word.vert_y, out_word.corner));
      end else begin
        want_vert = expected_verts.pop_front();
        check_field("vert_x", want_vert.vert_x, out_word.vert_x);
        check_field("vert_y", want_vert.vert_y, out_word.vert_y);
        check_field("tex_u", want_vert.tex_u, out_word.tex_u);
        check_field("tex_v", want_vert.tex_v, out_word.tex_v);
        check_field("color", want_vert.color, out_word.color);
        check_field("corner", want_vert.corner, out_word.corner);
        check_field("last_of_glyph", want_vert.last_of_glyph, out_word.last_of_glyph);
        verts_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Command driver: predict on acceptance, then present the next word or idle.
  // Hold the word while stalled; idle gaps start only between words.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_word);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_word <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Vertex receiver: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Hung: no word moved for %0d cycles, %0d vertices still outstanding",
               stuck_cycles, expected_verts.size());
      $display("glyph_quad_generator regression: fail");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic gqg_in_t rand_word();
    logic [127:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    return r[$bits(gqg_in_t)-1:0];
  endfunction

  // Unused fields keep random content so their bits toggle too
  function automatic gqg_in_t load_word(input logic [7:0] code, input logic [7:0] ax,
                                        input logic [7:0] ay, input logic [7:0] gw,
                                        input logic [7:0] gh, input logic signed [7:0] ox,
                                        input logic signed [7:0] oy, input logic [7:0] adv);
    gqg_in_t w;
    w = rand_word();
    w.func = FUNC_LOAD;
    w.char_code = code;
    w.atlas_x = ax;
    w.atlas_y = ay;
    w.glyph_w = gw;
    w.glyph_h = gh;
    w.off_x = ox;
    w.off_y = oy;
    w.advance = adv;
    return w;
  endfunction

  function automatic gqg_in_t start_word(input logic signed [15:0] sx,
                                         input logic signed [15:0] sy);
    gqg_in_t w;
    w = rand_word();
    w.func = FUNC_START;
    w.start_x = sx;
    w.start_y = sy;
    return w;
  endfunction

  function automatic gqg_in_t render_word(input logic [7:0] code);
    gqg_in_t w;
    w = rand_word();
    w.func = FUNC_RENDER;
    w.char_code = code;
    return w;
  endfunction

  // Pen coordinate within a few hundred pixels of either rail
  function automatic logic signed [15:0] near_rail();
    if ($urandom_range(0, 1) == 0) begin
      return 16'(32767 - $urandom_range(0, 300));
    end
    return 16'(-32768 + $urandom_range(0, 300));
  endfunction

  // Queue a word and remember loaded codes so renders can target them
  task automatic queue_cmd(input gqg_in_t w);
    if (w.func == FUNC_LOAD && !stim_loaded[w.char_code]) begin
      stim_loaded[w.char_code] = 1'b1;
      loaded_codes.push_back(w.char_code);
    end
    cmd_q.push_back(w);
  endtask

  task automatic add_directed();
    gqg_in_t w;
    // render before any load: unknown glyph
    queue_cmd(render_word(8'd65));
    w = rand_word();
    w.func = gqg_func_t'(FUNC_NONE);
    queue_cmd(w);
    // smallest and largest glyph entries, offsets at opposite extremes
    queue_cmd(load_word(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, -8'sd128, 8'sd127, 8'd0));
    queue_cmd(load_word(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'sd127, -8'sd128, 8'd255));
    // pen at the top rail: positions and pen advance clamp high
    queue_cmd(start_word(16'sh7FFF, 16'sh7FFF));
    queue_cmd(render_word(8'd255));
    queue_cmd(render_word(8'd255));
    // pen at the bottom rail: positions clamp low
    queue_cmd(start_word(16'sh8000, 16'sh8000));
    queue_cmd(render_word(8'd0));
    // ordinary glyph, rendered in a row so the pen walks right
    queue_cmd(load_word(8'd65, 8'd16, 8'd32, 8'd10, 8'd14, 8'sd1, -8'sd2, 8'd11));
    queue_cmd(start_word(16'sd100, 16'sd200));
    queue_cmd(render_word(8'd65));
    queue_cmd(render_word(8'd65));
    queue_cmd(render_word(8'd65));
    // overwrite an existing entry
    queue_cmd(load_word(8'd65, 8'd200, 8'd100, 8'd60, 8'd90, -8'sd5, 8'sd3, 8'd7));
    queue_cmd(render_word(8'd65));
    queue_cmd(render_word(8'd66));
    // alternating bit patterns
    queue_cmd(load_word(8'd128, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'sh55, 8'shAA, 8'hAA));
    queue_cmd(start_word(16'sd0, 16'sd0));
    queue_cmd(render_word(8'd128));
    queue_cmd(render_word(8'd0));
    w = rand_word();
    w.func = gqg_func_t'(FUNC_NONE);
    queue_cmd(w);
  endtask

  // Mostly load / start / render of loaded glyphs, with some noise mixed in.
  // Dropped words (unknown glyphs, unused func) do not count toward n.
  task automatic add_random(input int n);
    gqg_in_t w;
    int      useful;
    int      pick;
    useful = 0;
    while (useful < n) begin
      w = rand_word();
      pick = $urandom_range(0, 99);
      if (pick < 12 || loaded_codes.size() == 0) begin
        w.func = FUNC_LOAD;
        useful++;
      end else if (pick < 20) begin
        w.func = FUNC_START;
        if ($urandom_range(0, 3) == 0) begin
          w.start_x = near_rail();
          w.start_y = near_rail();
        end else if ($urandom_range(0, 1) == 0) begin
          w.start_x = 16'($urandom_range(0, 1000));
          w.start_y = 16'($urandom_range(0, 1000));
        end
        useful++;
      end else if (pick < 94) begin
        w.func = FUNC_RENDER;
        w.char_code = 8'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]);
        useful++;
      end else if (pick < 98) begin
        w.func = FUNC_RENDER;
        if (stim_loaded[w.char_code]) begin
          useful++;
        end
      end else begin
        w.func = gqg_func_t'(FUNC_NONE);
      end
      queue_cmd(w);
    end
  endtask

  // Let the queued words run out, then wait for every predicted vertex.
  // The sender holds off here until the block has fully drained.
  task automatic run_phase(input bit with_idling);
    idle_on = with_idling;
    do begin
      @(posedge clk);
    end while (cmd_q.size() != 0 || in_valid || expected_verts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; keep cfg_valid high across back-to-back writes
  task automatic write_reg(input gqg_cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_RISE_Y:      rise_now = data[15:0];
      CFG_LINE_HEIGHT: line_h_now = data[7:0];
      CFG_TEXT_COLOR:  color_now = data;
      default: begin
      end
    endcase
  endtask

  task automatic program_regs(input logic signed [15:0] rise, input logic [7:0] lh,
                              input logic [31:0] rgba);
    write_reg(CFG_RISE_Y, {{16{rise[15]}}, rise});
    write_reg(CFG_LINE_HEIGHT, {24'd0, lh});
    write_reg(CFG_TEXT_COLOR, rgba);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < DEF_GLYPH_COUNT; i++) begin
      glyph_known[i] = 1'b0;
    end
    pen_x_now = '0;
    pen_y_now = '0;
    rise_now = '0;
    line_h_now = LINE_HEIGHT_RST;
    color_now = TEXT_COLOR_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset defaults
    add_directed();
    run_phase(1'b1);

    // rise and line height at their low ends, black text
    program_regs(16'sh8000, 8'd0, 32'h0000_0000);
    add_random(PHASE_WORDS);
    run_phase(1'b1);

    // high ends, no idling on either side
    program_regs(16'sh7FFF, 8'hFF, 32'hFFFF_FFFF);
    add_random(PHASE_WORDS);
    run_phase(1'b0);

    program_regs(16'($urandom()), 8'($urandom()), $urandom());
    add_random(PHASE_WORDS);
    run_phase(1'b1);

    program_regs(16'sd0, LINE_HEIGHT_RST, $urandom());
    add_random(PHASE_WORDS);
    run_phase(1'b1);

    // closing stretch runs at full rate
    program_regs(16'($urandom()), 8'($urandom()), $urandom());
    add_random(PHASE_WORDS);
    run_phase(1'b0);

    if (expected_verts.size() != 0) begin
      flag($sformatf("%0d predicted vertices never arrived", expected_verts.size()));
    end
    $display("Sent %0d command words over six register settings: %0d characters drawn,",
             words_taken, chars_drawn);
    $display("%0d unknown glyphs dropped, %0d vertices compared, %0d mismatches.",
             chars_dropped, verts_checked, errors);
    if (errors == 0) begin
      $display("glyph_quad_generator regression: pass");
    end else begin
      $display("glyph_quad_generator regression: fail");
    end
    $finish;
  end

endmodule
